### hdl/sorq_pkg.sv
// Shared constants, codes and types for the stream-ordered queue with round-robin pick.
package sorq_pkg;

  // Table and stream sizes
  localparam int unsigned DEPTH   = 64;
  localparam int unsigned STREAMS = 16;

  // Field widths
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);
  localparam int unsigned SID_W  = 4;
  localparam int unsigned TAG_W  = 8;
  localparam int unsigned ACT_W  = 5;
  localparam int unsigned CMD_W  = 2;
  localparam int unsigned STAT_W = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_PICK   = 2'd1,
    CMD_FIND   = 2'd2,
    CMD_REMOVE = 2'd3
  } cmd_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK   = 2'd0,
    STAT_FULL = 2'd1,
    STAT_NONE = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_EXEC = 2'd1,
    S_PMOD = 2'd2,
    S_PSEL = 2'd3
  } state_e;

  // Broadcast control for the row of cells
  typedef struct packed {
    logic             ins_en;
    logic             rem_en;
    logic             match_tag;
    logic [SID_W-1:0] key_stream;
    logic [TAG_W-1:0] key_tag;
  } cell_ctl_t;

  // Round-robin choice
  typedef struct packed {
    logic             hit;
    logic [SID_W-1:0] stream;
  } rr_sel_t;

endpackage

### hdl/stream_ordered_queue_rr_pick.sv
// Top level: stream-ordered tag queue with round-robin pick built on a row of cells.
//
// Use: one command word enters on the in channel (cmd_i, stream_id_i, tag_i) and
// one result word leaves on the out channel (status_o, found_tag_o, found_stream_o).
// Commands: insert after the last entry of a stream, round-robin pick of the
// oldest entry of the next occupied stream, find the oldest entry of a stream,
// and remove a tag by identity. Pick leaves the entry in place.
// The table is a row of DEPTH cells kept sorted by stream; insert and remove
// shift the cells behind the insertion or removal point by one place.
// Insert, remove and find go from S_IDLE to S_EXEC, which loads the result.
// Pick passes S_PMOD, which subtracts the active count from the start point
// while the start point lies at or beyond it after a register change, then
// S_PSEL, which chooses the stream (or gives the result when no active stream
// has an entry), then S_EXEC. One command is in flight at a time; the next
// word is taken once the block is back in S_IDLE after its result is registered.
// The result holds in the output register while the receiver stalls, and the
// command in flight waits for that register to empty.
// Writes to active_streams are taken at any time (cfg_ready_o is held high) and
// are expected only while the block is idle.
// Reset empties the table, clears the round-robin start point and sets the
// active stream count to one.
module stream_ordered_queue_rr_pick (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // command channel
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [sorq_pkg::CMD_W-1:0]    cmd_i,
  input  logic [sorq_pkg::SID_W-1:0]    stream_id_i,
  input  logic [sorq_pkg::TAG_W-1:0]    tag_i,
  // result channel
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [sorq_pkg::STAT_W-1:0]   status_o,
  output logic [sorq_pkg::TAG_W-1:0]    found_tag_o,
  output logic [sorq_pkg::SID_W-1:0]    found_stream_o,
  // configuration channel
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [sorq_pkg::ACT_W-1:0]    active_streams_i
);

  localparam int unsigned D = sorq_pkg::DEPTH;

  sorq_pkg::state_e           state_q, state_d;
  sorq_pkg::cmd_e             cmd_q, cmd_d;
  logic [sorq_pkg::SID_W-1:0] key_stream_q, key_stream_d;
  logic [sorq_pkg::TAG_W-1:0] key_tag_q, key_tag_d;
  logic [sorq_pkg::CNT_W-1:0] count_q, count_d;
  logic [sorq_pkg::SID_W-1:0] rr_q, rr_d;
  logic [sorq_pkg::SID_W-1:0] start_q, start_d;
  logic [sorq_pkg::ACT_W-1:0] active_q;
  logic [sorq_pkg::ACT_W-1:0] act;
  logic [sorq_pkg::STREAMS-1:0] pres, pres_q;
  sorq_pkg::rr_sel_t          sel;
  sorq_pkg::cell_ctl_t        ctl;

  logic                        out_valid_q, out_valid_d;
  sorq_pkg::status_e           status_q, status_d;
  logic [sorq_pkg::TAG_W-1:0]  ftag_q, ftag_d;
  logic [sorq_pkg::SID_W-1:0]  fstream_q, fstream_d;
  logic                        out_free;
  logic [sorq_pkg::ACT_W-1:0]  next_rr;

  // Cell row wiring
  logic [sorq_pkg::SID_W-1:0] cell_stream [D];
  logic [sorq_pkg::TAG_W-1:0] cell_tag    [D];
  logic [D-1:0]               cell_stay;
  logic [D-1:0]               cell_first;
  logic [D:0]                 seen;
  logic [sorq_pkg::TAG_W-1:0] first_tag;

  // Configuration register
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= sorq_pkg::ACT_W'(1);
    end else if (cfg_valid_i) begin
      active_q <= active_streams_i;
    end
  end

  // Effective stream count, clamped to one..STREAMS
  always_comb begin
    if (active_q == '0) begin
      act = sorq_pkg::ACT_W'(1);
    end else if (active_q > sorq_pkg::ACT_W'(sorq_pkg::STREAMS)) begin
      act = sorq_pkg::ACT_W'(sorq_pkg::STREAMS);
    end else begin
      act = active_q;
    end
  end

  // Row of cells
  assign seen[0] = 1'b0;

  for (genvar i = 0; i < D; i++) begin : g_cell
    logic                       occ;
    logic                       left_stay;
    logic [sorq_pkg::SID_W-1:0] left_stream, right_stream;
    logic [sorq_pkg::TAG_W-1:0] left_tag, right_tag;

    assign occ = (sorq_pkg::CNT_W'(i) < count_q);

    if (i == 0) begin : g_head
      assign left_stay   = 1'b1;
      assign left_stream = ctl.key_stream;
      assign left_tag    = ctl.key_tag;
    end else begin : g_mid
      assign left_stay   = cell_stay[i-1];
      assign left_stream = cell_stream[i-1];
      assign left_tag    = cell_tag[i-1];
    end

    if (i == D - 1) begin : g_tail
      assign right_stream = cell_stream[i];
      assign right_tag    = cell_tag[i];
    end else begin : g_body
      assign right_stream = cell_stream[i+1];
      assign right_tag    = cell_tag[i+1];
    end

    sorq_cell u_cell (
      .clk_i          (clk_i),
      .ctl_i          (ctl),
      .occ_i          (occ),
      .left_stay_i    (left_stay),
      .left_stream_i  (left_stream),
      .left_tag_i     (left_tag),
      .right_stream_i (right_stream),
      .right_tag_i    (right_tag),
      .seen_i         (seen[i]),
      .stream_o       (cell_stream[i]),
      .tag_o          (cell_tag[i]),
      .stay_o         (cell_stay[i]),
      .seen_o         (seen[i+1]),
      .first_o        (cell_first[i])
    );
  end

  // Tag of the first matching cell, and occupied-stream vector
  always_comb begin
    first_tag = '0;
    pres      = '0;
    for (int i = 0; i < D; i++) begin
      if (cell_first[i]) begin
        first_tag = first_tag | cell_tag[i];
      end
      if (sorq_pkg::CNT_W'(i) < count_q) begin
        pres[cell_stream[i]] = 1'b1;
      end
    end
  end

  sorq_rr_sel u_rr_sel (
    .pres_i  (pres_q),
    .act_i   (act),
    .start_i (start_q),
    .sel_o   (sel)
  );

  assign out_free = !out_valid_q || out_ready_i;
  assign next_rr  = sorq_pkg::ACT_W'(key_stream_q) + sorq_pkg::ACT_W'(1);

  // Control and next state
  always_comb begin
    state_d      = state_q;
    cmd_d        = cmd_q;
    key_stream_d = key_stream_q;
    key_tag_d    = key_tag_q;
    count_d      = count_q;
    rr_d         = rr_q;
    start_d      = start_q;
    in_ready_o   = 1'b0;
    out_valid_d  = out_valid_q && !out_ready_i;
    status_d     = status_q;
    ftag_d       = ftag_q;
    fstream_d    = fstream_q;

    ctl.ins_en     = 1'b0;
    ctl.rem_en     = 1'b0;
    ctl.match_tag  = (cmd_q == sorq_pkg::CMD_REMOVE);
    ctl.key_stream = key_stream_q;
    ctl.key_tag    = key_tag_q;

    case (state_q)
      sorq_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_d        = sorq_pkg::cmd_e'(cmd_i);
          key_stream_d = stream_id_i;
          key_tag_d    = tag_i;
          start_d      = rr_q;
          state_d      = (sorq_pkg::cmd_e'(cmd_i) == sorq_pkg::CMD_PICK) ?
                         sorq_pkg::S_PMOD : sorq_pkg::S_EXEC;
        end
      end

      // Bring the start point into range, one subtraction a cycle
      sorq_pkg::S_PMOD: begin
        if (sorq_pkg::ACT_W'(start_q) >= act) begin
          start_d = sorq_pkg::SID_W'(sorq_pkg::ACT_W'(start_q) - act);
        end else begin
          state_d = sorq_pkg::S_PSEL;
        end
      end

      sorq_pkg::S_PSEL: begin
        if (sel.hit) begin
          key_stream_d = sel.stream;
          state_d      = sorq_pkg::S_EXEC;
        end else if (out_free) begin
          out_valid_d = 1'b1;
          status_d    = sorq_pkg::STAT_NONE;
          ftag_d      = '0;
          fstream_d   = '0;
          state_d     = sorq_pkg::S_IDLE;
        end
      end

      sorq_pkg::S_EXEC: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          status_d    = sorq_pkg::STAT_OK;
          ftag_d      = '0;
          fstream_d   = '0;
          state_d     = sorq_pkg::S_IDLE;
          case (cmd_q)
            sorq_pkg::CMD_INSERT: begin
              if (count_q == sorq_pkg::CNT_W'(D)) begin
                status_d = sorq_pkg::STAT_FULL;
              end else begin
                ctl.ins_en = 1'b1;
                count_d    = count_q + sorq_pkg::CNT_W'(1);
              end
            end
            sorq_pkg::CMD_REMOVE: begin
              if (seen[D]) begin
                ctl.rem_en = 1'b1;
                count_d    = count_q - sorq_pkg::CNT_W'(1);
              end else begin
                status_d = sorq_pkg::STAT_NONE;
              end
            end
            default: begin
              // find and pick share the oldest-of-stream lookup
              if (seen[D]) begin
                ftag_d    = first_tag;
                fstream_d = key_stream_q;
                if (cmd_q == sorq_pkg::CMD_PICK) begin
                  rr_d = (next_rr == act) ? '0 : sorq_pkg::SID_W'(next_rr);
                end
              end else begin
                status_d = sorq_pkg::STAT_NONE;
              end
            end
          endcase
        end
      end

      default: begin
        state_d = sorq_pkg::S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sorq_pkg::S_IDLE;
      count_q     <= '0;
      rr_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      rr_q        <= rr_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Working and result words
  always_ff @(posedge clk_i) begin
    cmd_q        <= cmd_d;
    key_stream_q <= key_stream_d;
    key_tag_q    <= key_tag_d;
    start_q      <= start_d;
    status_q     <= status_d;
    ftag_q       <= ftag_d;
    fstream_q    <= fstream_d;
    if (state_q == sorq_pkg::S_PMOD) begin
      pres_q <= pres;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign found_tag_o    = ftag_q;
  assign found_stream_o = fstream_q;

  // Checks
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= sorq_pkg::CNT_W'(D))
    else $error("entry count beyond table depth");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("second command taken while one is in flight");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> ($past(state_q) != sorq_pkg::S_IDLE))
    else $error("result word raised without a command in flight");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == sorq_pkg::STAT_FULL) |-> (count_q == sorq_pkg::CNT_W'(D)))
    else $error("full status reported on a table with room");

endmodule

### hdl/sorq_cell.sv
// One slot of the sorted tag row: holds a stream id and tag, shifts on insert and remove.
module sorq_cell (
  input  logic                         clk_i,
  input  sorq_pkg::cell_ctl_t          ctl_i,
  input  logic                         occ_i,
  input  logic                         left_stay_i,
  input  logic [sorq_pkg::SID_W-1:0]   left_stream_i,
  input  logic [sorq_pkg::TAG_W-1:0]   left_tag_i,
  input  logic [sorq_pkg::SID_W-1:0]   right_stream_i,
  input  logic [sorq_pkg::TAG_W-1:0]   right_tag_i,
  input  logic                         seen_i,
  output logic [sorq_pkg::SID_W-1:0]   stream_o,
  output logic [sorq_pkg::TAG_W-1:0]   tag_o,
  output logic                         stay_o,
  output logic                         seen_o,
  output logic                         first_o
);

  logic [sorq_pkg::SID_W-1:0] stream_q, stream_d;
  logic [sorq_pkg::TAG_W-1:0] tag_q, tag_d;
  logic                       hit;

  // Entry keeps its place on insert when it sorts at or before the new stream
  assign stay_o = occ_i && (stream_q <= ctl_i.key_stream);

  // Match on tag for remove, on stream for find and pick
  assign hit     = occ_i && (ctl_i.match_tag ? (tag_q == ctl_i.key_tag)
                                             : (stream_q == ctl_i.key_stream));
  assign seen_o  = seen_i | hit;
  assign first_o = hit & ~seen_i;

  // Next contents: new word, left neighbour, right neighbour or hold
  always_comb begin
    stream_d = stream_q;
    tag_d    = tag_q;
    if (ctl_i.ins_en && !stay_o) begin
      if (left_stay_i) begin
        stream_d = ctl_i.key_stream;
        tag_d    = ctl_i.key_tag;
      end else begin
        stream_d = left_stream_i;
        tag_d    = left_tag_i;
      end
    end else if (ctl_i.rem_en && seen_o) begin
      stream_d = right_stream_i;
      tag_d    = right_tag_i;
    end
  end

  always_ff @(posedge clk_i) begin
    stream_q <= stream_d;
    tag_q    <= tag_d;
  end

  assign stream_o = stream_q;
  assign tag_o    = tag_q;

endmodule

### hdl/sorq_rr_sel.sv
// Round-robin stream chooser over the occupied-stream vector.
module sorq_rr_sel (
  input  logic [sorq_pkg::STREAMS-1:0] pres_i,
  input  logic [sorq_pkg::ACT_W-1:0]   act_i,
  input  logic [sorq_pkg::SID_W-1:0]   start_i,
  output sorq_pkg::rr_sel_t            sel_o
);

  logic [sorq_pkg::STREAMS-1:0] elig;
  logic [sorq_pkg::STREAMS-1:0] upper;

  // Streams inside the active range, and those at or past the start point
  always_comb begin
    for (int j = 0; j < sorq_pkg::STREAMS; j++) begin
      elig[j]  = pres_i[j] && (sorq_pkg::ACT_W'(j) < act_i);
      upper[j] = elig[j] && (sorq_pkg::SID_W'(j) >= start_i);
    end
  end

  // Lowest set bit of the upper part wins, else wrap to the lowest eligible
  always_comb begin
    sel_o.hit    = |elig;
    sel_o.stream = '0;
    for (int j = sorq_pkg::STREAMS - 1; j >= 0; j--) begin
      if (elig[j]) begin
        sel_o.stream = sorq_pkg::SID_W'(j);
      end
    end
    if (|upper) begin
      for (int j = sorq_pkg::STREAMS - 1; j >= 0; j--) begin
        if (upper[j]) begin
          sel_o.stream = sorq_pkg::SID_W'(j);
        end
      end
    end
  end

endmodule
